// ----- rtl/msbbp_pkg.sv -----
// ============================================================================
// MSB-first bit packer package
// Shared types and constants for the bit packer front end, queue and back end.
// ============================================================================
package msbbp_pkg;

    // Widest field the block accepts; wider requests are clamped.
    localparam int MAX_FIELD_BITS = 32;
    localparam int VALUE_BITS     = 32;
    localparam int WIDTH_BITS     = 6;
    localparam int BYTE_BITS      = 8;
    localparam int FREE_BITS_W    = 4;
    localparam int POS_BITS       = 32;
    localparam int CAP_BITS       = 32;

    localparam logic [WIDTH_BITS-1:0] WIDTH_LIMIT =
        WIDTH_BITS'((MAX_FIELD_BITS < VALUE_BITS) ? MAX_FIELD_BITS : VALUE_BITS);

    localparam logic [FREE_BITS_W-1:0] FREE_FULL = FREE_BITS_W'(BYTE_BITS);
    localparam logic [BYTE_BITS-1:0]   BYTE_MASK = 8'hFF;
    localparam logic [CAP_BITS-1:0]    CAP_RESET = 32'hFFFF_FFFF;

    // Default depth of the queue between front and back end.
    localparam int FIFO_DEPTH_DEFAULT = 2;

    // Operation codes carried on the input tuser bit.
    localparam logic OP_PUT   = 1'b0;
    localparam logic OP_ALIGN = 1'b1;

    typedef struct packed {
        logic                  op;
        logic [VALUE_BITS-1:0] value;
        logic [WIDTH_BITS-1:0] width;
    } item_t;

endpackage

// ----- rtl/msbbp_front.sv -----
// ============================================================================
// Bit packer front end
// Accepts request transactions, unpacks them and clamps the field width.
// ============================================================================
module msbbp_front (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,   // [31:0] field_value, [37:32] field_width
    input  logic [0:0]           s_tuser,   // [0] operation
    output logic                 item_valid,
    input  logic                 item_ready,
    output msbbp_pkg::item_t     item
);

    logic [msbbp_pkg::WIDTH_BITS-1:0] raw_width;

    assign raw_width = s_tdata[37:32];

    always_comb begin
        item.op    = s_tuser[0];
        item.value = s_tdata[31:0];
        if (raw_width > msbbp_pkg::WIDTH_LIMIT) begin
            item.width = msbbp_pkg::WIDTH_LIMIT;
        end else begin
            item.width = raw_width;
        end
    end

    assign item_valid = s_tvalid;
    assign s_tready   = item_ready;

endmodule

// ----- rtl/msbbp_fifo.sv -----
// ============================================================================
// Bit packer request queue
// Small register queue that decouples the front end from the back end.
// ============================================================================
module msbbp_fifo #(
    parameter int DEPTH = msbbp_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  msbbp_pkg::item_t wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output msbbp_pkg::item_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    msbbp_pkg::item_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_wr, do_rd;

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/msbbp_back.sv -----
// ============================================================================
// Bit packer back end
// Packs queued requests into bytes, one byte per cycle while the output is not stalled, and drives results.
// ============================================================================
module msbbp_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  msbbp_pkg::item_t                item,
    input  logic                            cfg_valid,
    input  logic [msbbp_pkg::CAP_BITS-1:0]  cfg_data,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [47:0]                     m_tdata,  // [7:0] out_byte,
                                                      // [39:8] byte_position,
                                                      // [40] space_exhausted
    output logic                            m_tlast,
    output logic [0:0]                      m_tuser   // [0] byte_valid
);

    localparam int VW = msbbp_pkg::VALUE_BITS;
    localparam int WW = msbbp_pkg::WIDTH_BITS;
    localparam int FW = msbbp_pkg::FREE_BITS_W;
    localparam int BW = msbbp_pkg::BYTE_BITS;
    localparam int PW = msbbp_pkg::POS_BITS;

    // Control and packing state
    logic          busy_reg, busy_next;
    logic          emitted_reg, emitted_next;
    logic [WW-1:0] rem_reg, rem_next;
    logic [VW-1:0] val_reg, val_next;
    logic [BW-1:0] partial_reg, partial_next;
    logic [FW-1:0] free_reg, free_next;
    logic [PW-1:0] bw_reg, bw_next;
    logic          flag_reg, flag_next;
    logic [PW-1:0] cap_reg;

    // Output register
    logic          out_valid_reg, out_valid_next;
    logic [BW-1:0] out_byte_reg, out_byte_next;
    logic          out_bv_reg, out_bv_next;
    logic [PW-1:0] out_pos_reg, out_pos_next;
    logic          out_last_reg, out_last_next;
    logic          out_flag_reg, out_flag_next;

    // Step datapath
    logic          out_free, step_en, load_en;
    logic          complete, done, room, emit_byte, emit_status;
    logic [WW-1:0] shift_amt, rem1;
    logic [FW-1:0] free1, free2;
    logic [BW-1:0] partial1, partial2, byte_val, chunk, tail_bits;
    logic [VW-1:0] shifted;
    logic [2*BW-1:0] tail_wide;
    logic [PW-1:0] bw_inc;

    assign out_free   = !out_valid_reg || m_tready;
    assign step_en    = busy_reg && out_free;
    assign load_en    = !busy_reg && item_valid;
    assign item_ready = !busy_reg;
    assign bw_inc     = bw_reg + 1'b1;
    assign room       = (bw_reg < cap_reg);

    always_comb begin
        complete  = ({2'b00, free_reg} <= rem_reg);
        shift_amt = rem_reg - {2'b00, free_reg};
        shifted   = val_reg >> shift_amt;
        chunk     = shifted[BW-1:0] & (msbbp_pkg::BYTE_MASK >> (msbbp_pkg::FREE_FULL - free_reg));
        byte_val  = partial_reg | chunk;

        if (complete) begin
            rem1     = shift_amt;
            free1    = msbbp_pkg::FREE_FULL;
            partial1 = '0;
        end else begin
            rem1     = rem_reg;
            free1    = free_reg;
            partial1 = partial_reg;
        end

        // After this step no further byte fills up: fold in the leftover bits.
        done      = (rem1 < {2'b00, free1});
        free2     = free1 - rem1[FW-1:0];
        tail_bits = val_reg[BW-1:0]
                    & (msbbp_pkg::BYTE_MASK >> (msbbp_pkg::FREE_FULL - rem1[FW-1:0]));
        tail_wide = {{BW{1'b0}}, tail_bits} << free2;
        partial2  = partial1 | tail_wide[BW-1:0];

        emit_byte   = complete && room;
        emit_status = done && !emitted_reg && !emit_byte;
    end

    always_comb begin
        busy_next      = busy_reg;
        emitted_next   = emitted_reg;
        rem_next       = rem_reg;
        val_next       = val_reg;
        partial_next   = partial_reg;
        free_next      = free_reg;
        bw_next        = bw_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_bv_next    = out_bv_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;
        out_flag_next  = out_flag_reg;

        if (out_free) begin
            out_valid_next = 1'b0;
        end

        if (load_en) begin
            busy_next    = 1'b1;
            emitted_next = 1'b0;
            if (item.op == msbbp_pkg::OP_ALIGN) begin
                // Padding fills exactly the open slots of an unfinished byte.
                val_next = '0;
                rem_next = (free_reg < msbbp_pkg::FREE_FULL) ? {2'b00, free_reg} : '0;
            end else begin
                val_next = item.value;
                rem_next = item.width;
            end
        end else if (step_en) begin
            rem_next     = rem1;
            partial_next = done ? partial2 : partial1;
            free_next    = done ? free2 : free1;
            busy_next    = !done;
            if (complete && !room) begin
                flag_next = 1'b1;
            end
            if (emit_byte) begin
                emitted_next   = 1'b1;
                bw_next        = bw_inc;
                out_valid_next = 1'b1;
                out_byte_next  = byte_val;
                out_bv_next    = 1'b1;
                out_pos_next   = bw_reg;
                // Later bytes of this request are dropped once capacity is hit.
                out_last_next  = done || (bw_inc == cap_reg);
                out_flag_next  = flag_reg;
            end else if (emit_status) begin
                out_valid_next = 1'b1;
                out_byte_next  = '0;
                out_bv_next    = 1'b0;
                out_pos_next   = bw_reg;
                out_last_next  = 1'b1;
                out_flag_next  = flag_reg || complete;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            emitted_reg   <= 1'b0;
            partial_reg   <= '0;
            free_reg      <= msbbp_pkg::FREE_FULL;
            bw_reg        <= '0;
            flag_reg      <= 1'b0;
            cap_reg       <= msbbp_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            emitted_reg   <= emitted_next;
            partial_reg   <= partial_next;
            free_reg      <= free_next;
            bw_reg        <= bw_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        val_reg      <= val_next;
        out_byte_reg <= out_byte_next;
        out_bv_reg   <= out_bv_next;
        out_pos_reg  <= out_pos_next;
        out_last_reg <= out_last_next;
        out_flag_reg <= out_flag_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_flag_reg, out_pos_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_bv_reg;

`ifndef SYNTHESIS
    // The free bit count always names between one and eight open slots.
    a_free_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (free_reg != '0) && (free_reg <= msbbp_pkg::FREE_FULL))
        else $error("free bit count out of range");

    // The capacity flag only clears on reset.
    a_flag_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        flag_reg |=> flag_reg)
        else $error("space flag cleared");

    // The byte count only ever advances by one.
    a_bw_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (bw_reg != $past(bw_reg)) |-> (bw_reg == $past(bw_reg) + 1'b1))
        else $error("byte count jumped");

    // A status-only result is always the final result of its request.
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_bv_reg) |-> out_last_reg)
        else $error("status result not marked last");

    // A new request is taken only after the previous one has fully finished.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !done) |-> !item_ready)
        else $error("request taken while busy");
`endif

endmodule

// ----- rtl/msb_first_bit_packer.sv -----
// ============================================================================
// MSB-first bit packer
// Packs variable-width fields most significant bit first into a byte stream.
// ============================================================================
// Each request transaction either puts the low field_width bits (clamped to
// 32) of field_value or pads zeros to the next byte boundary. Every byte that
// fills up is sent as one result transaction with its offset; a request that
// completes no byte sends one status-only result with byte_valid low. Bytes
// past capacity_bytes are dropped and space_exhausted stays set until reset.
// A request is queued in the request queue right away while it has room;
// the back end then loads it and turns out each byte that fills up in turn,
// paced by its single-byte-per-cycle sequencer and output register, which
// hold while the output is stalled. Capacity writes must only be issued
// while the block is idle.
module msb_first_bit_packer #(
    parameter int FIFO_DEPTH = msbbp_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] field_value, [37:32] field_width
    input  logic [0:0]  s_tuser,   // [0] operation
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,  // capacity_bytes
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] out_byte, [39:8] byte_position,
                                   // [40] space_exhausted
    output logic        m_tlast,   // last_of_run
    output logic [0:0]  m_tuser    // [0] byte_valid
);

    msbbp_pkg::item_t front_item, back_item;
    logic             front_valid, front_ready;
    logic             back_valid, back_ready;

    assign cfg_ready = 1'b1;

    msbbp_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    msbbp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_data  (front_item),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_data  (back_item)
    );

    msbbp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .item       (back_item),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule
